>>> rtl/crc16e_pkg.sv
// Shared types, register indexes and bit functions for the configurable CRC-16 engine.
// No dependencies.
`default_nettype none

package crc16e_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CfgIdxW   = 2;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLYNOMIAL = 2'd0,
    REG_INIT_VALUE = 2'd1,
    REG_REFLECTED  = 2'd2,
    REG_XOR_OUT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    crc_t polynomial;
    crc_t init_value;
    logic reflected;
    crc_t xor_out;
  } cfg_t;

  localparam crc_t  POLY_RESET  = 16'h8005;
  localparam crc_t  INIT_RESET  = 16'h0000;
  localparam logic  REFL_RESET  = 1'b1;
  localparam crc_t  XOR_RESET   = 16'h0000;

  function automatic byte_t rev8(input byte_t v);
    byte_t r;
    for (int i = 0; i < ByteWidth; i++) begin
      r[i] = v[ByteWidth-1-i];
    end
    return r;
  endfunction

  function automatic crc_t rev16(input crc_t v);
    crc_t r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[i] = v[CrcWidth-1-i];
    end
    return r;
  endfunction

  // Eight LSB-first shift steps against the reversed polynomial.
  function automatic crc_t crc_byte_steps(input crc_t c_in, input crc_t rpoly);
    crc_t c;
    c = c_in;
    for (int i = 0; i < ByteWidth; i++) begin
      c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crc16e_core.sv
// Running CRC register and message state; absorbs one byte per accepted item.
// Depends on crc16e_pkg.
`default_nettype none

module crc16e_core
  import crc16e_pkg::*;
(
  input  wire  logic  clk,
  input  wire  logic  rst,
  input  wire  cfg_t  cfg,
  input  wire  logic  accept,
  input  wire  byte_t data_byte,
  input  wire  logic  last_byte,
  output       logic  push,
  output       crc_t  crc_value
);

  crc_t  crc_reg;
  crc_t  crc_reg_next;
  logic  in_message;
  crc_t  start_value;
  byte_t byte_in;

  always_comb begin
    start_value  = in_message ? crc_reg : cfg.init_value;
    byte_in      = cfg.reflected ? data_byte : rev8(data_byte);
    crc_reg_next = crc_byte_steps(start_value ^ {8'h00, byte_in}, rev16(cfg.polynomial));
    crc_value    = (cfg.reflected ? crc_reg_next : rev16(crc_reg_next)) ^ cfg.xor_out;
    push         = accept & last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= '0;
      in_message <= 1'b0;
    end else if (accept) begin
      crc_reg    <= crc_reg_next;
      in_message <= ~last_byte;
    end
  end

endmodule

`default_nettype wire

>>> rtl/crc16e_out.sv
// Result register with a skid stage between the CRC core and the output stream.
// Depends on crc16e_pkg.
`default_nettype none

module crc16e_out
  import crc16e_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic push,
  input  wire  crc_t push_value,
  output       logic space,
  output       logic m_tvalid,
  input  wire  logic m_tready,
  output       crc_t m_tdata
);

  crc_t main_value;
  crc_t skid_value;
  logic main_valid;
  logic skid_valid;
  logic pop;

  assign pop      = main_valid & m_tready;
  assign space    = ~skid_valid;
  assign m_tvalid = main_valid;
  assign m_tdata  = main_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_value <= skid_value;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_value <= push_value;
      end else begin
        skid_value <= push_value;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/configurable_crc16_engine.sv
// Top level of the configurable CRC-16 engine: configuration registers, core and output stage.
// Depends on crc16e_pkg, crc16e_core and crc16e_out.
//
// Message bytes arrive on the s_ stream, one per item; the item with s_tlast set closes the
// message and yields its 16-bit CRC on the m_ stream. Each byte is absorbed by eight unrolled
// shift steps of the CRC register, so one item is taken every clock while s_tready is high;
// the closing byte's result is registered behind any earlier result. A two-entry output
// stage holds results while m_tready is low; s_tready drops only when both entries are full.
// Write configuration through cfg_we/cfg_index/cfg_data while no message is in flight.
`default_nettype none

module configurable_crc16_engine
  import crc16e_pkg::*;
(
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                cfg_we,
  input  wire  logic [CfgIdxW-1:0]  cfg_index,
  input  wire  logic [CrcWidth-1:0] cfg_data,
  input  wire  logic                s_tvalid,
  output       logic                s_tready,
  input  wire  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  wire  logic                s_tlast,   // last_byte
  output       logic                m_tvalid,
  input  wire  logic                m_tready,
  output       logic [15:0]         m_tdata    // [15:0] crc_value
);

  cfg_t cfg;
  logic accept;
  logic push;
  logic space;
  crc_t crc_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polynomial <= POLY_RESET;
      cfg.init_value <= INIT_RESET;
      cfg.reflected  <= REFL_RESET;
      cfg.xor_out    <= XOR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_POLYNOMIAL: cfg.polynomial <= cfg_data;
        REG_INIT_VALUE: cfg.init_value <= cfg_data;
        REG_REFLECTED:  cfg.reflected  <= cfg_data[0];
        REG_XOR_OUT:    cfg.xor_out    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = space;
  assign accept   = s_tvalid & space;

  crc16e_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .push      (push),
    .crc_value (crc_value)
  );

  crc16e_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (crc_value),
    .space      (space),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for configurable_crc16_engine: directed and random messages
// under several CRC settings, with random stalls on both streams and a long output hold-off.
// Depends on crc16e_pkg and the engine RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16e_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_POLYNOMIAL;
  crc_t     cfg_data = '0;
  logic     s_tvalid = 1'b0;
  logic     s_tready;
  byte_t    s_tdata = '0;
  logic     s_tlast = 1'b0;
  logic     m_tvalid;
  logic     m_tready = 1'b0;
  crc_t     m_tdata;

  configurable_crc16_engine dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor copy of the configuration and message state
  crc_t cur_poly = POLY_RESET;
  crc_t cur_init = INIT_RESET;
  logic cur_refl = REFL_RESET;
  crc_t cur_xor  = XOR_RESET;
  crc_t run_crc  = '0;
  logic msg_open = 1'b0;

  crc_t pending_crcs[$];

  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned crcs_checked  = 0;
  int unsigned messages_sent = 0;
  int unsigned config_loads  = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  bit          hold_request  = 1'b0;
  int unsigned sink_span     = 0;
  int unsigned sink_mode     = 0;
  int unsigned sink_held     = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic crc_t mirror(crc_t v, int unsigned n);
    crc_t r;
    r = '0;
    for (int i = 0; i < n; i++) r[i] = v[n-1-i];
    return r;
  endfunction

  function automatic void absorb_byte(byte_t d, logic last);
    crc_t c;
    crc_t rpoly;
    rpoly = mirror(cur_poly, CrcWidth);
    c = msg_open ? run_crc : cur_init;
    c = c ^ (cur_refl ? crc_t'(d) : mirror(crc_t'(d), ByteWidth));
    for (int i = 0; i < ByteWidth; i++) c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    run_crc  = c;
    msg_open = !last;
    if (last) begin
      pending_crcs.push_back((cur_refl ? c : mirror(c, CrcWidth)) ^ cur_xor);
      messages_sent++;
    end
  endfunction

  // checker
  always @(posedge clk) begin : crc_checker
    crc_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_crcs.size() == 0) begin
        $error("crc_value: no result expected, got %h", m_tdata);
        error_count++;
      end else begin
        want = pending_crcs.pop_front();
        crcs_checked++;
        if (m_tdata !== want) begin
          $error("crc_value: expected %h, actual %h", want, m_tdata);
          error_count++;
        end
      end
    end
  end

  // receiver pacing: random stretches, long hold-off on request
  always @(posedge clk) begin
    if (hold_request && sink_held < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      sink_held++;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        sink_held = 0;
      end
      if (sink_span == 0) begin
        sink_mode = $urandom_range(0, 3);
        sink_span = $urandom_range(4, 40);
      end
      sink_span--;
      case (sink_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= sink_span[1];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_crcs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(byte_t d, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_byte(d, last);
    bytes_sent++;
  endtask

  task automatic sender_idle();
    s_tvalid <= 1'b0;
  endtask

  // wait for every result, then let the pipeline empty
  task automatic settle();
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, crc_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_POLYNOMIAL: cur_poly = value;
      REG_INIT_VALUE: cur_init = value;
      REG_REFLECTED:  cur_refl = value[0];
      REG_XOR_OUT:    cur_xor  = value;
      default: ;
    endcase
  endtask

  task automatic load_config(crc_t poly, crc_t init, crc_t refl_word, crc_t xo);
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_INIT_VALUE, init);
    write_reg(REG_REFLECTED, refl_word);
    write_reg(REG_XOR_OUT, xo);
    cfg_we <= 1'b0;
    config_loads++;
  endtask

  task automatic test_reset_defaults();
    for (int k = 1; k <= 9; k++) send_byte(byte_t'(8'h30 + k), k == 9);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    sender_idle();
  endtask

  task automatic test_config_extremes();
    settle();
    load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    sender_idle();
    settle();
    load_config(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    sender_idle();
    settle();
    load_config(16'h1021, 16'hFFFF, 16'h0000, 16'h0000);
    send_byte(8'h31, 1'b0);
    send_byte(8'h32, 1'b1);
    sender_idle();
  endtask

  task automatic test_mid_message_write();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    sender_idle();
    settle();
    write_reg(REG_POLYNOMIAL, 16'h8005);
    write_reg(REG_REFLECTED, 16'hFFFF);
    write_reg(REG_XOR_OUT, 16'h5555);
    write_reg(REG_INIT_VALUE, 16'hC3A9);
    cfg_we <= 1'b0;
    config_loads++;
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h9A, 1'b1);
    sender_idle();
  endtask

  task automatic test_output_backpressure();
    settle();
    hold_request = 1'b1;
    for (int k = 0; k < 16; k++) send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
    while (hold_request) @(posedge clk);
    for (int k = 0; k < 6; k++) send_byte(byte_t'($urandom_range(0, 255)), k == 5);
    sender_idle();
    settle();
    for (int k = 0; k < 6; k++) send_byte(byte_t'($urandom_range(0, 255)), k[0]);
    sender_idle();
  endtask

  task automatic random_config();
    crc_t poly;
    crc_t init;
    crc_t xo;
    case ($urandom_range(0, 4))
      0: poly = 16'h8005;
      1: poly = 16'h1021;
      2: poly = 16'hFFFF;
      3: poly = 16'h0000;
      default: poly = crc_t'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0: init = 16'h0000;
      1: init = 16'hFFFF;
      default: init = crc_t'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0: xo = 16'h0000;
      1: xo = 16'hFFFF;
      default: xo = crc_t'($urandom);
    endcase
    load_config(poly, init, crc_t'($urandom), xo);
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      random_config();
      repeat ($urandom_range(8, 30)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) len = $urandom_range(40, 64);
        else if (pick < 4) len = 1;
        else len = $urandom_range(2, 16);
        for (int k = 1; k <= len; k++) send_byte(byte_t'($urandom_range(0, 255)), k == len);
        sent += len;
      end
      // leave a message open across the next settings change
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        sent += len;
      end
      sender_idle();
    end
    settle();
    send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
    sender_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_mid_message_write();
    test_output_backpressure();
    test_random_messages();
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_crcs.size() != 0) begin
      $error("crc_value: %0d results never arrived", pending_crcs.size());
      error_count++;
    end
    $display("covered %0d bytes in %0d messages over %0d register settings",
             bytes_sent, messages_sent, config_loads + 1);
    $display("checked %0d CRC results, %0d mismatches", crcs_checked, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/crc16e_pkg.sv
rtl/crc16e_core.sv
rtl/crc16e_out.sv
rtl/configurable_crc16_engine.sv
tb/tb.sv
